### rtl/core/tspd_pkg.sv
// Package with the shared constants and types of the transport stream PES demultiplexer.
`default_nettype none
package tspd_pkg;
    localparam int unsigned PACKET_BYTES = 188;
    localparam int unsigned POS_W = 8;
    localparam logic [7:0] SYNC_BYTE = 8'h47;

    typedef enum logic [1:0] {
        CFG_AUDIO_PID    = 2'd0,
        CFG_AUDIO_ENABLE = 2'd1,
        CFG_VIDEO_PID    = 2'd2,
        CFG_VIDEO_ENABLE = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_SKIP    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_FILL    = 2'd2,
        PH_PAYLOAD = 2'd3
    } pes_phase_t;

    typedef enum logic [1:0] {
        STREAM_NONE  = 2'd0,
        STREAM_AUDIO = 2'd1,
        STREAM_VIDEO = 2'd2
    } packet_stream_t;

    typedef struct packed {
        pes_phase_t  phase;
        logic [16:0] index;
        logic [16:0] total;
        logic [8:0]  header_length;
        logic [1:0]  flags;
        logic [32:0] pts;
        logic [32:0] dts;
        logic [1:0]  stamp_valid;
    } pes_state_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        stream_select;
        logic        chunk_first;
        logic        chunk_last;
        logic        unit_start;
        logic [32:0] pts_value;
        logic        pts_valid;
        logic [32:0] dts_value;
        logic        dts_valid;
    } result_t;
endpackage
`default_nettype wire

### rtl/core/ts_pes_demux.sv
// Top level of the transport stream PES demultiplexer.
// The block takes one transport stream byte per beat and gives at most one
// payload byte per beat. Each input byte is handled by one pass of
// combinational logic over the packet and PES state, and its result is held
// in an output register, so a byte can be accepted in every cycle: one byte
// per cycle sustained unless stalled, result in the next cycle. Input
// ready drops only while a result is waiting and the output is stalled. The
// block hunts for the 0x47 sync byte, frames 188-byte packets, keeps packets
// whose PID matches the enabled audio or video PID (audio wins when both
// match), skips the adaptation field and parses one PES header per stream.
// Timestamps appear only on the first payload byte after a PES header and
// read as zero when not valid. Configuration writes are expected while idle.
`default_nettype none
module ts_pes_demux (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  stream_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       payload_byte,
    output logic             stream_select,
    output logic             chunk_first,
    output logic             chunk_last,
    output logic             unit_start,
    output logic [32:0]      pts_value,
    output logic             pts_valid,
    output logic [32:0]      dts_value,
    output logic             dts_valid
);
    // Configuration registers.
    logic [12:0] audio_pid_reg, video_pid_reg;
    logic        audio_enable_reg, video_enable_reg;

    // Packet framing state.
    logic [tspd_pkg::POS_W-1:0] byte_position_reg, byte_position_next;
    logic [12:0] packet_pid_reg, packet_pid_next;
    tspd_pkg::packet_stream_t packet_stream_reg, packet_stream_next;
    logic        packet_unit_start_reg, packet_unit_start_next;
    logic [1:0]  adaptation_control_reg, adaptation_control_next;
    logic [8:0]  adaptation_skip_reg, adaptation_skip_next;
    logic        chunk_started_reg, chunk_started_next;
    tspd_pkg::pes_state_t pes_reg [2];
    tspd_pkg::pes_state_t pes_next [2];

    // Output stage.
    logic              out_valid_reg, out_valid_next;
    tspd_pkg::result_t result_reg, result_next;

    logic accept;
    logic emit;
    tspd_pkg::result_t res;

    assign cfg_ready = 1'b1;
    // A new byte enters whenever the output stage is empty or being drained.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_pid_reg    <= 13'h1fff;
            audio_enable_reg <= 1'b0;
            video_pid_reg    <= 13'h1fff;
            video_enable_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (tspd_pkg::cfg_index_t'(cfg_index))
                tspd_pkg::CFG_AUDIO_PID:    audio_pid_reg    <= cfg_data;
                tspd_pkg::CFG_AUDIO_ENABLE: audio_enable_reg <= cfg_data[0];
                tspd_pkg::CFG_VIDEO_PID:    video_pid_reg    <= cfg_data;
                tspd_pkg::CFG_VIDEO_ENABLE: video_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Packet framing and PES parser step for one byte; computes the new state and
    // raises emit when the byte is a payload byte of the selected stream.
    always_comb
    begin
        logic        s;
        logic [7:0]  b;
        logic        pes_go;
        logic        is_last_pos;
        logic [16:0] idx;
        logic [16:0] idx_inc;
        logic [8:0]  code;
        logic        bounded;
        tspd_pkg::pes_state_t p;

        b   = stream_byte;
        s   = 1'b0;
        pes_go = 1'b0;
        emit = 1'b0;
        res = '0;
        is_last_pos = ({1'b0, byte_position_reg} + 9'd1) >= 9'(tspd_pkg::PACKET_BYTES);

        byte_position_next      = byte_position_reg;
        packet_pid_next         = packet_pid_reg;
        packet_stream_next      = packet_stream_reg;
        packet_unit_start_next  = packet_unit_start_reg;
        adaptation_control_next = adaptation_control_reg;
        adaptation_skip_next    = adaptation_skip_reg;
        chunk_started_next      = chunk_started_reg;
        pes_next[0] = pes_reg[0];
        pes_next[1] = pes_reg[1];

        if (byte_position_reg == '0)
        begin
            if (b == tspd_pkg::SYNC_BYTE)
            begin
                chunk_started_next = 1'b0;
                packet_stream_next = tspd_pkg::STREAM_NONE;
                byte_position_next = tspd_pkg::POS_W'(1);
            end
        end
        else
        begin
            if (byte_position_reg == 8'd1)
            begin
                packet_pid_next        = {b[4:0], 8'h00};
                packet_unit_start_next = b[6];
            end
            else if (byte_position_reg == 8'd2)
            begin
                packet_pid_next = {packet_pid_reg[12:8], b};
                if (audio_enable_reg && packet_pid_next == audio_pid_reg)
                    packet_stream_next = tspd_pkg::STREAM_AUDIO;
                else if (video_enable_reg && packet_pid_next == video_pid_reg)
                    packet_stream_next = tspd_pkg::STREAM_VIDEO;
                else
                    packet_stream_next = tspd_pkg::STREAM_NONE;
            end
            else if (byte_position_reg == 8'd3)
            begin
                adaptation_control_next = b[5:4];
                if (b[5:4] == 2'd0 || b[5:4] == 2'd2)
                    packet_stream_next = tspd_pkg::STREAM_NONE;
                else if (packet_stream_reg != tspd_pkg::STREAM_NONE && b[5:4] == 2'd1
                         && packet_unit_start_reg)
                begin
                    s = (packet_stream_reg == tspd_pkg::STREAM_VIDEO);
                    pes_next[s].phase = tspd_pkg::PH_HEADER;
                    pes_next[s].index = '0;
                end
            end
            else if (packet_stream_reg != tspd_pkg::STREAM_NONE)
            begin
                s = (packet_stream_reg == tspd_pkg::STREAM_VIDEO);
                if (adaptation_control_reg == 2'd1)
                    pes_go = 1'b1;
                else if (byte_position_reg == 8'd4)
                begin
                    adaptation_skip_next = {1'b0, b};
                    if ((9'd5 + {1'b0, b}) < 9'(tspd_pkg::PACKET_BYTES)
                        && packet_unit_start_reg)
                    begin
                        pes_next[s].phase = tspd_pkg::PH_HEADER;
                        pes_next[s].index = '0;
                    end
                end
                else if (adaptation_skip_reg != '0)
                    adaptation_skip_next = adaptation_skip_reg - 9'd1;
                else
                    pes_go = 1'b1;
            end
            byte_position_next = is_last_pos ? '0 : byte_position_reg + 8'd1;
        end

        // PES byte handling for the selected stream.
        p       = pes_reg[s];
        idx     = p.index;
        idx_inc = idx + 17'd1;
        code    = {1'b1, b};
        bounded = (p.total != '0);
        if (pes_go)
        begin
            case (p.phase)
                tspd_pkg::PH_HEADER:
                begin
                    if ((idx <= 17'd1 && b != 8'h00) || (idx == 17'd2 && b != 8'h01))
                        p.phase = tspd_pkg::PH_SKIP;
                    else if (idx == 17'd3 && !((code >= 9'h1c0 && code <= 9'h1df)
                             || (code >= 9'h1e0 && code <= 9'h1ef) || code == 9'h1bd))
                        p.phase = tspd_pkg::PH_SKIP;
                    else
                    begin
                        if (idx == 17'd4) p.total = {1'b0, b, 8'h00};
                        if (idx == 17'd5) p.total = {p.total[16:8], b};
                        if (idx == 17'd7) p.flags = b[7:6];
                        p.index = idx_inc;
                        if (idx == 17'd8)
                        begin
                            p.header_length = {1'b0, b} + 9'd9;
                            if (p.total != '0)
                                p.total = p.total + 17'd6;
                            if (b == 8'h00)
                            begin
                                p.stamp_valid = '0;
                                p.phase = tspd_pkg::PH_PAYLOAD;
                            end
                            else
                                p.phase = tspd_pkg::PH_FILL;
                        end
                    end
                end
                tspd_pkg::PH_FILL:
                begin
                    if (idx == 17'd9)  p.pts = {b[3:1], 30'd0};
                    if (idx == 17'd10) p.pts[29:22] = b;
                    if (idx == 17'd11) p.pts[21:15] = b[7:1];
                    if (idx == 17'd12) p.pts[14:7] = b;
                    if (idx == 17'd13) p.pts[6:0] = b[7:1];
                    if (idx == 17'd14) p.dts = {b[3:1], 30'd0};
                    if (idx == 17'd15) p.dts[29:22] = b;
                    if (idx == 17'd16) p.dts[21:15] = b[7:1];
                    if (idx == 17'd17) p.dts[14:7] = b;
                    if (idx == 17'd18) p.dts[6:0] = b[7:1];
                    p.index = idx_inc;
                    if (idx_inc == {8'd0, p.header_length})
                    begin
                        p.stamp_valid[0] = (p.flags[1]) && (p.header_length >= 9'd14);
                        p.stamp_valid[1] = (p.flags == 2'd3) && (p.header_length >= 9'd19);
                        p.phase = tspd_pkg::PH_PAYLOAD;
                    end
                end
                tspd_pkg::PH_PAYLOAD:
                begin
                    if (!(bounded && idx >= p.total))
                    begin
                        emit = 1'b1;
                        res.payload_byte  = b;
                        res.stream_select = s;
                        res.chunk_first   = !chunk_started_reg;
                        res.chunk_last    = is_last_pos || (bounded && idx_inc == p.total);
                        res.unit_start    = packet_unit_start_reg;
                        res.pts_valid     = p.stamp_valid[0];
                        res.pts_value     = p.stamp_valid[0] ? p.pts : '0;
                        res.dts_valid     = p.stamp_valid[1];
                        res.dts_value     = p.stamp_valid[1] ? p.dts : '0;
                        if (bounded)
                            p.index = idx_inc;
                        p.stamp_valid = '0;
                        chunk_started_next = 1'b1;
                    end
                end
                default: ;
            endcase
            pes_next[s] = p;
        end
    end

    assign out_valid_next = accept ? emit : (out_valid_reg && !out_ready);
    assign result_next    = (accept && emit) ? res : result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg      <= '0;
            packet_pid_reg         <= '0;
            packet_stream_reg      <= tspd_pkg::STREAM_NONE;
            packet_unit_start_reg  <= 1'b0;
            adaptation_control_reg <= '0;
            adaptation_skip_reg    <= '0;
            chunk_started_reg      <= 1'b0;
            pes_reg[0]             <= '0;
            pes_reg[1]             <= '0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                byte_position_reg      <= byte_position_next;
                packet_pid_reg         <= packet_pid_next;
                packet_stream_reg      <= packet_stream_next;
                packet_unit_start_reg  <= packet_unit_start_next;
                adaptation_control_reg <= adaptation_control_next;
                adaptation_skip_reg    <= adaptation_skip_next;
                chunk_started_reg      <= chunk_started_next;
                pes_reg[0]             <= pes_next[0];
                pes_reg[1]             <= pes_next[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = result_reg.payload_byte;
    assign stream_select = result_reg.stream_select;
    assign chunk_first   = result_reg.chunk_first;
    assign chunk_last    = result_reg.chunk_last;
    assign unit_start    = result_reg.unit_start;
    assign pts_value     = result_reg.pts_value;
    assign pts_valid     = result_reg.pts_valid;
    assign dts_value     = result_reg.dts_value;
    assign dts_valid     = result_reg.dts_valid;
endmodule
`default_nettype wire

### rtl/core/tspd_checker.sv
// Port-level checker for the transport stream PES demultiplexer, with its bind.
`default_nettype none
module tspd_assertions (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [32:0] pts_value,
    input wire logic        pts_valid,
    input wire logic [32:0] dts_value,
    input wire logic        dts_valid
);
    // A stalled result holds its beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    // The input side is open whenever the output stage is empty.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output stage");
    // Timestamps read as zero unless flagged.
    a_pts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pts_valid |-> pts_value == '0)
        else $error("pts value without pts valid");
    a_dts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dts_valid |-> dts_value == '0)
        else $error("dts value without dts valid");
endmodule

bind ts_pes_demux tspd_assertions u_tspd_assertions (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .pts_value(pts_value),
    .pts_valid(pts_valid), .dts_value(dts_value), .dts_valid(dts_valid)
);
`default_nettype wire
